FILE: design/sdspi_pkg.sv
package sdspi_pkg;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_DESELECT = 3'd1,
        PH_DUMMY    = 3'd2,
        PH_READY    = 3'd3,
        PH_FRAME    = 3'd4,
        PH_STUFF    = 3'd5,
        PH_RESP     = 3'd6,
        PH_TMO      = 3'd7
    } phase_t;

    localparam logic REG_READY_POLL_LIMIT    = 1'b0;
    localparam logic REG_RESPONSE_POLL_LIMIT = 1'b1;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_BYTE  = 1'b1;

    localparam logic [1:0] ST_RESPONSE       = 2'd0;
    localparam logic [1:0] ST_READY_TIMEOUT  = 2'd1;
    localparam logic [1:0] ST_RESP_TIMEOUT   = 2'd2;
    localparam logic [1:0] ST_PREFIX_FAILED  = 2'd3;

    localparam logic [7:0] POLL_LIMIT_RESET = 8'd50;
    localparam logic [7:0] FILL_BYTE        = 8'hFF;
    localparam logic [7:0] CRC_CMD0         = 8'h95;
    localparam logic [7:0] CRC_CMD8         = 8'h87;
    localparam logic [7:0] CRC_OTHER        = 8'h01;
    localparam logic [1:0] CMD_START_BITS   = 2'b01;

    localparam logic [5:0] CMD_GO_IDLE      = 6'd0;
    localparam logic [5:0] CMD_SEND_IF_COND = 6'd8;
    localparam logic [5:0] CMD_STOP         = 6'd12;
    localparam logic [5:0] CMD_APP          = 6'd55;

    localparam logic [2:0] FRAME_LAST = 3'd5;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  command_code;
        logic [31:0] argument;
        logic [7:0]  rx_byte;
    } req_item_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       select_active;
        logic       done_res;
        logic [7:0] response;
        logic [1:0] status;
    } res_item_t;

    function automatic logic [7:0] frame_byte(
        input logic [2:0]  k,
        input logic [5:0]  idx,
        input logic [31:0] arg
    );
        logic [7:0] b;
        case (k)
            3'd0: b = {CMD_START_BITS, idx};
            3'd1: b = arg[31:24];
            3'd2: b = arg[23:16];
            3'd3: b = arg[15:8];
            3'd4: b = arg[7:0];
            default:
            begin
                if (idx == CMD_GO_IDLE)
                    b = CRC_CMD0;
                else if (idx == CMD_SEND_IF_COND)
                    b = CRC_CMD8;
                else
                    b = CRC_OTHER;
            end
        endcase
        return b;
    endfunction

endpackage

FILE: design/sdspi_req_if.sv
interface sdspi_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [7:0]  command_code;
    logic [31:0] argument;
    logic [7:0]  rx_byte;

    modport source (output valid, req_type, command_code, argument, rx_byte, input ready);
    modport sink   (input valid, req_type, command_code, argument, rx_byte, output ready);
endinterface

FILE: design/sdspi_res_if.sv
interface sdspi_res_if;
    logic       valid;
    logic       ready;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       select_active;
    logic       done_res;
    logic [7:0] response;
    logic [1:0] status;

    modport source (output valid, tx_valid, tx_byte, select_active, done_res, response,
                    status, input ready);
    modport sink   (input valid, tx_valid, tx_byte, select_active, done_res, response,
                    status, output ready);
endinterface

FILE: design/sdspi_in_stage.sv
module sdspi_in_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    sdspi_req_if.sink              req,
    input  logic                   take,
    output logic                   item_valid,
    output sdspi_pkg::req_item_t   item
);

    logic                 valid_reg;
    sdspi_pkg::req_item_t item_reg;

    assign req.ready  = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (req.valid && req.ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            item_reg <= '{req_type: req.req_type, command_code: req.command_code,
                          argument: req.argument, rx_byte: req.rx_byte};
        end
    end

endmodule

FILE: design/sdspi_seq.sv
module sdspi_seq (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [7:0]             cfg_data,
    input  logic                   fire,
    input  sdspi_pkg::req_item_t   item,
    output sdspi_pkg::res_item_t   result
);

    logic [7:0]        ready_limit_reg;
    logic [7:0]        resp_limit_reg;

    sdspi_pkg::phase_t phase_reg, phase_next;
    logic [7:0]        poll_counter_reg, poll_counter_next;
    logic [2:0]        byte_index_reg, byte_index_next;
    logic [7:0]        saved_command_reg, saved_command_next;
    logic [31:0]       saved_argument_reg, saved_argument_next;
    logic              prefix_pending_reg, prefix_pending_next;

    logic [5:0]        cur_idx;
    logic [31:0]       cur_arg;
    logic [7:0]        poll_dec;
    logic [5:0]        start_idx;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_limit_reg <= sdspi_pkg::POLL_LIMIT_RESET;
            resp_limit_reg  <= sdspi_pkg::POLL_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sdspi_pkg::REG_READY_POLL_LIMIT:    ready_limit_reg <= cfg_data;
                sdspi_pkg::REG_RESPONSE_POLL_LIMIT: resp_limit_reg  <= cfg_data;
                default:                            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= sdspi_pkg::PH_IDLE;
            poll_counter_reg   <= '0;
            byte_index_reg     <= '0;
            saved_command_reg  <= '0;
            saved_argument_reg <= '0;
            prefix_pending_reg <= 1'b0;
        end
        else
        begin
            phase_reg          <= phase_next;
            poll_counter_reg   <= poll_counter_next;
            byte_index_reg     <= byte_index_next;
            saved_command_reg  <= saved_command_next;
            saved_argument_reg <= saved_argument_next;
            prefix_pending_reg <= prefix_pending_next;
        end
    end

    assign cur_idx  = prefix_pending_reg ? sdspi_pkg::CMD_APP : saved_command_reg[5:0];
    assign cur_arg  = prefix_pending_reg ? 32'd0 : saved_argument_reg;
    assign poll_dec = poll_counter_reg - 8'd1;
    assign start_idx = item.command_code[7] ? sdspi_pkg::CMD_APP : item.command_code[5:0];

    always_comb
    begin
        phase_next          = phase_reg;
        poll_counter_next   = poll_counter_reg;
        byte_index_next     = byte_index_reg;
        saved_command_next  = saved_command_reg;
        saved_argument_next = saved_argument_reg;
        prefix_pending_next = prefix_pending_reg;
        result              = '0;

        if (fire)
        begin
            if (item.req_type == sdspi_pkg::REQ_START)
            begin
                saved_command_next  = item.command_code;
                saved_argument_next = item.argument;
                prefix_pending_next = item.command_code[7];
                result.tx_valid     = 1'b1;
                if (start_idx == sdspi_pkg::CMD_STOP)
                begin
                    phase_next           = sdspi_pkg::PH_FRAME;
                    byte_index_next      = 3'd0;
                    result.tx_byte       = sdspi_pkg::frame_byte(3'd0, start_idx,
                                                                 item.argument);
                    result.select_active = 1'b1;
                end
                else
                begin
                    phase_next     = sdspi_pkg::PH_DESELECT;
                    result.tx_byte = sdspi_pkg::FILL_BYTE;
                end
            end
            else
            begin
                case (phase_reg)
                    sdspi_pkg::PH_DESELECT:
                    begin
                        phase_next           = sdspi_pkg::PH_DUMMY;
                        result.tx_valid      = 1'b1;
                        result.tx_byte       = sdspi_pkg::FILL_BYTE;
                        result.select_active = 1'b1;
                    end
                    sdspi_pkg::PH_DUMMY:
                    begin
                        phase_next           = sdspi_pkg::PH_READY;
                        poll_counter_next    = ready_limit_reg;
                        result.tx_valid      = 1'b1;
                        result.tx_byte       = sdspi_pkg::FILL_BYTE;
                        result.select_active = 1'b1;
                    end
                    sdspi_pkg::PH_READY:
                    begin
                        result.tx_valid = 1'b1;
                        if (item.rx_byte == sdspi_pkg::FILL_BYTE)
                        begin
                            phase_next           = sdspi_pkg::PH_FRAME;
                            byte_index_next      = 3'd0;
                            result.tx_byte       = sdspi_pkg::frame_byte(3'd0, cur_idx, cur_arg);
                            result.select_active = 1'b1;
                        end
                        else
                        begin
                            poll_counter_next = poll_dec;
                            result.tx_byte    = sdspi_pkg::FILL_BYTE;
                            if (poll_dec == 8'd0)
                                phase_next = sdspi_pkg::PH_TMO;
                            else
                                result.select_active = 1'b1;
                        end
                    end
                    sdspi_pkg::PH_FRAME:
                    begin
                        result.tx_valid      = 1'b1;
                        result.select_active = 1'b1;
                        if (byte_index_reg < sdspi_pkg::FRAME_LAST)
                        begin
                            byte_index_next = byte_index_reg + 3'd1;
                            result.tx_byte  = sdspi_pkg::frame_byte(byte_index_reg + 3'd1,
                                                                    cur_idx, cur_arg);
                        end
                        else
                        begin
                            result.tx_byte = sdspi_pkg::FILL_BYTE;
                            if (cur_idx == sdspi_pkg::CMD_STOP)
                            begin
                                phase_next = sdspi_pkg::PH_STUFF;
                            end
                            else
                            begin
                                phase_next        = sdspi_pkg::PH_RESP;
                                poll_counter_next = resp_limit_reg;
                            end
                        end
                    end
                    sdspi_pkg::PH_STUFF:
                    begin
                        phase_next           = sdspi_pkg::PH_RESP;
                        poll_counter_next    = resp_limit_reg;
                        result.tx_valid      = 1'b1;
                        result.tx_byte       = sdspi_pkg::FILL_BYTE;
                        result.select_active = 1'b1;
                    end
                    sdspi_pkg::PH_RESP:
                    begin
                        if (item.rx_byte[7])
                            poll_counter_next = poll_dec;
                        if (item.rx_byte[7] && poll_dec != 8'd0)
                        begin
                            result.tx_valid      = 1'b1;
                            result.tx_byte       = sdspi_pkg::FILL_BYTE;
                            result.select_active = 1'b1;
                        end
                        else if (prefix_pending_reg && item.rx_byte <= 8'd1)
                        begin
                            prefix_pending_next = 1'b0;
                            result.tx_valid     = 1'b1;
                            if (saved_command_reg[5:0] == sdspi_pkg::CMD_STOP)
                            begin
                                phase_next           = sdspi_pkg::PH_FRAME;
                                byte_index_next      = 3'd0;
                                result.tx_byte       = sdspi_pkg::frame_byte(3'd0,
                                                           saved_command_reg[5:0],
                                                           saved_argument_reg);
                                result.select_active = 1'b1;
                            end
                            else
                            begin
                                phase_next     = sdspi_pkg::PH_DESELECT;
                                result.tx_byte = sdspi_pkg::FILL_BYTE;
                            end
                        end
                        else
                        begin
                            phase_next          = sdspi_pkg::PH_IDLE;
                            prefix_pending_next = 1'b0;
                            byte_index_next     = 3'd0;
                            result.done_res     = 1'b1;
                            result.response     = item.rx_byte;
                            if (prefix_pending_reg)
                                result.status = sdspi_pkg::ST_PREFIX_FAILED;
                            else if (item.rx_byte[7])
                                result.status = sdspi_pkg::ST_RESP_TIMEOUT;
                            else
                                result.status = sdspi_pkg::ST_RESPONSE;
                        end
                    end
                    sdspi_pkg::PH_TMO:
                    begin
                        phase_next          = sdspi_pkg::PH_IDLE;
                        prefix_pending_next = 1'b0;
                        byte_index_next     = 3'd0;
                        result.done_res     = 1'b1;
                        result.response     = sdspi_pkg::FILL_BYTE;
                        result.status       = prefix_pending_reg ? sdspi_pkg::ST_PREFIX_FAILED
                                                                 : sdspi_pkg::ST_READY_TIMEOUT;
                    end
                    default:
                    begin
                        phase_next = sdspi_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

`ifndef SYNTHESIS
    a_done_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
        fire && result.done_res |=> phase_reg == sdspi_pkg::PH_IDLE)
        else $error("finished request did not return to idle");

    a_byte_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        byte_index_reg <= sdspi_pkg::FRAME_LAST)
        else $error("frame byte index out of range");

    a_prefix_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        prefix_pending_reg |-> phase_reg != sdspi_pkg::PH_IDLE)
        else $error("prefix pending while idle");

    a_exchange_or_done: assert property (@(posedge clk) disable iff (!rst_n)
        fire && result.tx_valid |-> !result.done_res && result.status == sdspi_pkg::ST_RESPONSE)
        else $error("exchange result carries completion fields");
`endif

endmodule

FILE: design/sdspi_out_stage.sv
module sdspi_out_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  sdspi_pkg::res_item_t   result,
    output logic                   free,
    sdspi_res_if.source            res
);

    logic                 valid_reg;
    sdspi_pkg::res_item_t data_reg;

    assign free              = !valid_reg || res.ready;
    assign res.valid         = valid_reg;
    assign res.tx_valid      = data_reg.tx_valid;
    assign res.tx_byte       = data_reg.tx_byte;
    assign res.select_active = data_reg.select_active;
    assign res.done_res      = data_reg.done_res;
    assign res.response      = data_reg.response;
    assign res.status        = data_reg.status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

endmodule

FILE: design/sd_spi_command_engine_core.sv
// Path: an accepted request waits in the request register, then its result is loaded
// into the result register once that stage is free. Throughput: one request per cycle
// while res.ready holds; the sequencer decides each exchange byte combinationally.
// Reset: both request and result stages empty, sequencer idle, both poll limits 50.
module sd_spi_command_engine_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    sdspi_req_if.sink   req,
    sdspi_res_if.source res
);

    logic                 item_valid;
    sdspi_pkg::req_item_t item;
    sdspi_pkg::res_item_t result;
    logic                 free;
    logic                 fire;

    assign fire = item_valid && free;

    sdspi_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    sdspi_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fire      (fire),
        .item      (item),
        .result    (result)
    );

    sdspi_out_stage u_out (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (fire),
        .result (result),
        .free   (free),
        .res    (res)
    );

endmodule
